/* rtl/tdpg_pkg.sv */
// Shared types and constants for the trigger delay pulse generator.
// Used by every module of the block; no dependencies.
`default_nettype none
package tdpg_pkg;

  localparam int COUNT_BITS = 16;
  localparam int MAX_PULSE  = 5000;
  localparam int DELAY_BITS = 16;
  localparam int WIDTH_BITS = 13;
  localparam int DATA_BITS  = 16;
  localparam int INDEX_BITS = 3;
  localparam int END_BITS   = DELAY_BITS + 1;
  localparam int CMP_BITS   = (COUNT_BITS > END_BITS) ? COUNT_BITS : END_BITS;
  localparam int SPAN_LIMIT = 16'hFFFF - MAX_PULSE;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [DELAY_BITS-1:0] delay_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [1:0]            phase_t;

  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_TRIG = 2'd1;
  localparam phase_t PH_DIS  = 2'd2;
  localparam phase_t PH_GEN  = 2'd3;

  localparam logic [INDEX_BITS-1:0] REG_DELAY  = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_WIDTH  = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_PERIOD = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_GEN    = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_ENABLE = 3'd4;

  localparam delay_t RST_DELAY  = DELAY_BITS'(10000);
  localparam width_t RST_WIDTH  = WIDTH_BITS'(500);
  localparam delay_t RST_PERIOD = DELAY_BITS'(10000);
  localparam delay_t SPAN_MAX   = DELAY_BITS'(SPAN_LIMIT);
  localparam width_t WIDTH_MAX  = WIDTH_BITS'(MAX_PULSE);
  localparam count_t COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef struct packed {
    delay_t delay;
    width_t width;
    delay_t period;
    logic   gen_mode;
    logic   enable;
    logic   restart;
  } cfg_t;

  typedef struct packed {
    logic   pulse;
    phase_t phase;
  } res_t;

endpackage
`default_nettype wire

/* rtl/tdpg_cfg.sv */
// Configuration registers with saturation on write and train restart pulse.
// Depends on tdpg_pkg.
`default_nettype none
module tdpg_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [tdpg_pkg::INDEX_BITS-1:0]  cfg_index,
  input  wire [tdpg_pkg::DATA_BITS-1:0]   cfg_data,
  output tdpg_pkg::cfg_t                  cfg
);

  tdpg_pkg::delay_t delay_r, delay_nxt, period_r, period_nxt, span_in;
  tdpg_pkg::width_t width_r, width_nxt, width_in;
  logic             gen_r, gen_nxt, en_r, en_nxt;

  assign span_in  = cfg_data[tdpg_pkg::DELAY_BITS-1:0];
  assign width_in = cfg_data[tdpg_pkg::WIDTH_BITS-1:0];

  always_comb begin
    delay_nxt  = delay_r;
    width_nxt  = width_r;
    period_nxt = period_r;
    gen_nxt    = gen_r;
    en_nxt     = en_r;
    if (cfg_we) begin
      case (cfg_index)
        tdpg_pkg::REG_DELAY:
          delay_nxt = (span_in > tdpg_pkg::SPAN_MAX) ? tdpg_pkg::SPAN_MAX : span_in;
        tdpg_pkg::REG_WIDTH:
          width_nxt = (width_in > tdpg_pkg::WIDTH_MAX) ? tdpg_pkg::WIDTH_MAX : width_in;
        tdpg_pkg::REG_PERIOD:
          period_nxt = (span_in > tdpg_pkg::SPAN_MAX) ? tdpg_pkg::SPAN_MAX : span_in;
        tdpg_pkg::REG_GEN:    gen_nxt = cfg_data[0];
        tdpg_pkg::REG_ENABLE: en_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= tdpg_pkg::RST_DELAY;
      width_r  <= tdpg_pkg::RST_WIDTH;
      period_r <= tdpg_pkg::RST_PERIOD;
      gen_r    <= 1'b0;
      en_r     <= 1'b1;
    end else begin
      delay_r  <= delay_nxt;
      width_r  <= width_nxt;
      period_r <= period_nxt;
      gen_r    <= gen_nxt;
      en_r     <= en_nxt;
    end
  end

  assign cfg.delay    = delay_r;
  assign cfg.width    = width_r;
  assign cfg.period   = period_r;
  assign cfg.gen_mode = gen_r;
  assign cfg.enable   = en_r;
  assign cfg.restart  = cfg_we && gen_r &&
                        (cfg_index == tdpg_pkg::REG_WIDTH ||
                         cfg_index == tdpg_pkg::REG_PERIOD);

endmodule
`default_nettype wire

/* rtl/tdpg_core.sv */
// Per-tick state update: edge detect, delayed pulse, generated train, disable.
// Depends on tdpg_pkg.
`default_nettype none
module tdpg_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               step,
  input  wire               trig,
  input  tdpg_pkg::cfg_t    cfg,
  output tdpg_pkg::res_t    res
);

  tdpg_pkg::phase_t phase_r, phase_nxt, ph;
  tdpg_pkg::count_t cnt_r, cnt_nxt, c;
  tdpg_pkg::delay_t ld_r, ld_nxt;
  tdpg_pkg::width_t lw_r, lw_nxt;
  logic             prev_r, lvl_r, lvl_nxt, lvl0, edge_seen;
  tdpg_pkg::cmp_t   c_x, end_x, ld_x, per_x, wid_x;

  assign edge_seen = trig && !prev_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ld_nxt    = ld_r;
    lw_nxt    = lw_r;
    lvl_nxt   = lvl_r;
    res.pulse = 1'b0;
    res.phase = tdpg_pkg::PH_DIS;
    ph        = phase_r;
    c         = cnt_r;
    lvl0      = lvl_r;
    c_x       = '0;
    end_x     = '0;
    ld_x      = '0;
    per_x     = tdpg_pkg::CMP_BITS'(cfg.period);
    wid_x     = tdpg_pkg::CMP_BITS'(cfg.width);
    if (!cfg.enable) begin
      phase_nxt = tdpg_pkg::PH_DIS;
      lvl_nxt   = 1'b0;
    end else if (cfg.gen_mode) begin
      if (phase_r != tdpg_pkg::PH_GEN) begin
        c    = '0;
        lvl0 = 1'b0;
      end
      c_x = tdpg_pkg::CMP_BITS'(c);
      if (c_x == wid_x) begin
        lvl_nxt = 1'b0;
      end else if (c_x == per_x) begin
        lvl_nxt = 1'b1;
      end else begin
        lvl_nxt = lvl0;
      end
      phase_nxt = tdpg_pkg::PH_GEN;
      res.phase = tdpg_pkg::PH_GEN;
      cnt_nxt   = (c_x >= per_x || c == tdpg_pkg::COUNT_MAX) ? '0 :
                  c + tdpg_pkg::COUNT_BITS'(1);
    end else begin
      if (phase_r == tdpg_pkg::PH_DIS || phase_r == tdpg_pkg::PH_GEN) begin
        ph = tdpg_pkg::PH_IDLE;
        c  = '0;
      end
      if (ph == tdpg_pkg::PH_IDLE && edge_seen) begin
        ld_nxt = cfg.delay;
        lw_nxt = cfg.width;
        c      = '0;
        ph     = tdpg_pkg::PH_TRIG;
      end
      res.phase = ph;
      phase_nxt = ph;
      cnt_nxt   = c;
      lvl_nxt   = 1'b0;
      if (ph == tdpg_pkg::PH_TRIG) begin
        c_x   = tdpg_pkg::CMP_BITS'(c);
        ld_x  = tdpg_pkg::CMP_BITS'(ld_nxt);
        end_x = tdpg_pkg::CMP_BITS'(ld_nxt) + tdpg_pkg::CMP_BITS'(lw_nxt);
        lvl_nxt = (c_x >= ld_x) && (c_x < end_x);
        if (c_x >= end_x || c == tdpg_pkg::COUNT_MAX) begin
          phase_nxt = tdpg_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = c + tdpg_pkg::COUNT_BITS'(1);
        end
      end
    end
    res.pulse = lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tdpg_pkg::PH_IDLE;
      cnt_r   <= '0;
      ld_r    <= tdpg_pkg::RST_DELAY;
      lw_r    <= tdpg_pkg::RST_WIDTH;
      prev_r  <= 1'b0;
      lvl_r   <= 1'b0;
    end else if (cfg.restart) begin
      cnt_r <= '0;
      lvl_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ld_r    <= ld_nxt;
      lw_r    <= lw_nxt;
      prev_r  <= trig;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tdpg_out.sv */
// Result register: holds one item until taken, refills in the same cycle.
// Depends on tdpg_pkg.
`default_nettype none
module tdpg_out (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             load,
  input  tdpg_pkg::res_t  res,
  input  wire             out_ready,
  output logic            out_valid,
  output logic            free,
  output tdpg_pkg::res_t  held
);

  logic           valid_r, valid_nxt;
  tdpg_pkg::res_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign held      = data_r;

endmodule
`default_nettype wire

/* rtl/trigger_delay_pulse_generator_unit.sv */
// Each accepted item's result is registered and becomes valid in the next cycle.
// Throughput: one item per cycle unless a result waits on out_ready; state
// update is combinational and feeds one result register, refilled when taken.
// Reset: synchronous active-low; registers take their default settings,
// phase idle, counter zero, pulse level low, no result pending.
`default_nettype none
module trigger_delay_pulse_generator_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_trigger_level,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            out_pulse_out,
  output logic [1:0]                      out_phase,
  input  wire                             cfg_we,
  input  wire [tdpg_pkg::INDEX_BITS-1:0]  cfg_index,
  input  wire [tdpg_pkg::DATA_BITS-1:0]   cfg_data
);

  tdpg_pkg::cfg_t cfg;
  tdpg_pkg::res_t res, held;
  logic           free, step;

  assign in_ready = free;
  assign step     = in_valid && free;

  tdpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdpg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .trig  (in_trigger_level),
    .cfg   (cfg),
    .res   (res)
  );

  tdpg_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .held      (held)
  );

  assign out_pulse_out = held.pulse;
  assign out_phase     = held.phase;

endmodule
`default_nettype wire

/* rtl/tdpg_checker.sv */
// Port-level checks for the trigger delay pulse generator, bound to the top.
// Depends on tdpg_pkg.
`default_nettype none
module tdpg_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_pulse_out,
  input wire [1:0] out_phase
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_out) && $stable(out_phase))
    else $error("result changed while stalled");

  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_dis_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == tdpg_pkg::PH_DIS |-> !out_pulse_out)
    else $error("pulse high while disabled");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == tdpg_pkg::PH_IDLE |-> !out_pulse_out)
    else $error("pulse high while idle");

endmodule

bind trigger_delay_pulse_generator_unit tdpg_checker u_tdpg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pulse_out (out_pulse_out),
  .out_phase     (out_phase)
);
`default_nettype wire
